FILE: hw/rtl/abp_pkg.sv
package abp_pkg;

  // Table sizes and counter width.
  localparam int PHT_ENTRIES  = 4096;
  localparam int BIAS_ENTRIES = 4096;
  localparam int CTR_BITS     = 2;

  // Fixed field widths.
  localparam int ADDR_W  = 32;
  localparam int HIST_W  = 12;
  localparam int SHIFT_W = 2;
  localparam int REQ_W   = 3;

  // Derived index widths.
  localparam int PHT_IDX_W  = $clog2(PHT_ENTRIES);
  localparam int BIAS_IDX_W = $clog2(BIAS_ENTRIES);

  // The clearing pass walks the larger of the two tables.
  localparam int CLR_DEPTH = (PHT_ENTRIES > BIAS_ENTRIES) ? PHT_ENTRIES : BIAS_ENTRIES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  // Bias table entry: {bias_set, bias}.
  localparam int BIAS_W = 2;

  // History keeps only the bits that can reach a counter index.
  localparam logic [HIST_W-1:0] HIST_MASK = HIST_W'(PHT_ENTRIES - 1);

  // Counter limits; a counter above the threshold says agree.
  localparam logic [CTR_BITS-1:0] CTR_MAX    = {CTR_BITS{1'b1}};
  localparam logic [CTR_BITS-1:0] CTR_THRESH = CTR_BITS'((1 << (CTR_BITS - 1)) - 1);

  localparam logic [SHIFT_W-1:0] INST_SHIFT_RST = 2'd2;

  // Queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Request codes as they arrive on the input port.
  localparam logic [REQ_W-1:0] REQ_LOOKUP   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UNCOND   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RESOLVE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RESTORE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_BTB_MISS = 3'd4;

  // Request class after decode; unknown codes become KIND_NOP.
  typedef enum logic [2:0] {
    KIND_LOOKUP,
    KIND_UNCOND,
    KIND_RESOLVE,
    KIND_RESTORE,
    KIND_BTB_MISS,
    KIND_NOP
  } kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // One queued request.
  typedef struct packed {
    kind_t                 kind;
    logic [BIAS_IDX_W-1:0] bidx;
    logic [PHT_IDX_W-1:0]  pbase;
    logic                  taken;
    logic                  squashed;
    logic [HIST_W-1:0]     saved;
  } q_entry_t;

  // History bits that land in the counter index.
  function automatic logic [PHT_IDX_W-1:0] hist_idx(input logic [HIST_W-1:0] h);
    logic [31:0] t;
    t = 32'(h) & 32'(PHT_ENTRIES - 1);
    return t[PHT_IDX_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/abp_ram.sv
module abp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/abp_front.sv
module abp_front import abp_pkg::*; (
  input  logic [REQ_W-1:0]   req_type,
  input  logic [ADDR_W-1:0]  branch_addr,
  input  logic               taken,
  input  logic               squashed,
  input  logic [HIST_W-1:0]  saved_history,
  input  logic [SHIFT_W-1:0] inst_shift,
  output q_entry_t           entry
);

  logic [ADDR_W-1:0] shifted;
  logic [ADDR_W-1:0] bsel;
  logic [ADDR_W-1:0] psel;

  // Drop the low address bits and cut the result to each table's index.
  assign shifted = branch_addr >> inst_shift;
  assign bsel    = shifted & ADDR_W'(BIAS_ENTRIES - 1);
  assign psel    = shifted & ADDR_W'(PHT_ENTRIES - 1);

  // Classify the request and build the queue beat.
  always_comb begin
    entry          = '0;
    entry.bidx     = bsel[BIAS_IDX_W-1:0];
    entry.pbase    = psel[PHT_IDX_W-1:0];
    entry.taken    = taken;
    entry.squashed = squashed;
    entry.saved    = saved_history;
    unique case (req_type)
      REQ_LOOKUP:   entry.kind = KIND_LOOKUP;
      REQ_UNCOND:   entry.kind = KIND_UNCOND;
      REQ_RESOLVE:  entry.kind = KIND_RESOLVE;
      REQ_RESTORE:  entry.kind = KIND_RESTORE;
      REQ_BTB_MISS: entry.kind = KIND_BTB_MISS;
      default:      entry.kind = KIND_NOP;
    endcase
  end

endmodule

FILE: hw/rtl/abp_queue.sv
module abp_queue import abp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty,
  output logic     full
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt = push ? next_ptr(wptr_r) : wptr_r;
    rptr_nxt = pop ? next_ptr(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  assign head  = mem_r[rptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));

  // The fill count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count exceeds depth");

endmodule

FILE: hw/rtl/abp_back.sv
module abp_back import abp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_entry_t          head,
  input  logic              empty,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  output logic              out_prediction,
  output logic [HIST_W-1:0] out_history_snapshot,
  output logic              out_bias_bit,
  output logic              out_agree_pred
);

  back_state_t           state_r, state_nxt;
  q_entry_t              ent_r;
  logic [PHT_IDX_W-1:0]  pidx_r;
  logic [PHT_IDX_W-1:0]  pidx_rd;
  logic [HIST_W-1:0]     hist_r, hist_nxt;
  logic                  clr_active_r;
  logic [CLR_W-1:0]      clr_idx_r;

  logic                  ctr_we;
  logic [PHT_IDX_W-1:0]  ctr_waddr;
  logic [CTR_BITS-1:0]   ctr_wdata;
  logic [CTR_BITS-1:0]   ctr_rdata;
  logic                  bias_we;
  logic [BIAS_IDX_W-1:0] bias_waddr;
  logic [BIAS_W-1:0]     bias_wdata;
  logic [BIAS_W-1:0]     bias_rdata;

  logic                  rd_bias;
  logic                  rd_set;
  logic                  ctr_agree;
  logic                  train_up;
  logic [CTR_BITS-1:0]   ctr_upd;
  logic                  res_pred;
  logic                  res_bias;
  logic                  res_agree;

  logic                  out_valid_r;
  logic                  out_pred_r;
  logic [HIST_W-1:0]     out_snap_r;
  logic                  out_bias_r;
  logic                  out_agree_r;

  // Counter index: a resolve uses its snapshot, everything else the live history.
  assign pidx_rd = head.pbase ^
                   hist_idx((head.kind == KIND_RESOLVE) ? head.saved : hist_r);

  // Sequencer: read both tables in IDLE, update them in EXEC.
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!empty && !clr_active_r) begin
          pop       = 1'b1;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the request and its counter index for the update cycle.
  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r  <= head;
      pidx_r <= pidx_rd;
    end
  end

  // Decode the table data and work out the result.
  assign rd_bias   = bias_rdata[0];
  assign rd_set    = bias_rdata[1];
  assign ctr_agree = (ctr_rdata > CTR_THRESH);
  assign train_up  = (ent_r.taken == rd_bias);

  always_comb begin
    if (train_up) begin
      ctr_upd = (ctr_rdata == CTR_MAX) ? ctr_rdata : ctr_rdata + 1'b1;
    end else begin
      ctr_upd = (ctr_rdata == '0) ? ctr_rdata : ctr_rdata - 1'b1;
    end
  end

  always_comb begin
    res_pred  = 1'b0;
    res_bias  = 1'b0;
    res_agree = 1'b0;
    hist_nxt  = hist_r;
    unique case (ent_r.kind)
      KIND_LOOKUP: begin
        res_bias  = rd_bias;
        res_agree = ctr_agree;
        res_pred  = ctr_agree ? rd_bias : ~rd_bias;
        hist_nxt  = {hist_r[HIST_W-2:0], res_pred} & HIST_MASK;
      end
      KIND_UNCOND: begin
        res_bias  = 1'b1;
        res_agree = 1'b1;
        res_pred  = 1'b1;
        hist_nxt  = {hist_r[HIST_W-2:0], 1'b1} & HIST_MASK;
      end
      KIND_RESOLVE: begin
        res_bias  = rd_bias;
        res_agree = train_up;
        if (ent_r.squashed) begin
          hist_nxt = {ent_r.saved[HIST_W-2:0], ent_r.taken} & HIST_MASK;
        end
      end
      KIND_RESTORE: begin
        hist_nxt = ent_r.saved & HIST_MASK;
      end
      KIND_BTB_MISS: begin
        hist_nxt = hist_r & {HIST_MASK[HIST_W-1:1], 1'b0};
      end
      KIND_NOP: begin
        hist_nxt = hist_r;
      end
      default: hist_nxt = hist_r;
    endcase
  end

  // Table writes: the clearing pass after reset, then resolve training.
  always_comb begin
    ctr_we     = 1'b0;
    ctr_waddr  = pidx_r;
    ctr_wdata  = ctr_upd;
    bias_we    = 1'b0;
    bias_waddr = ent_r.bidx;
    bias_wdata = {1'b1, ent_r.taken};
    if (clr_active_r) begin
      ctr_we     = (32'(clr_idx_r) < 32'(PHT_ENTRIES));
      ctr_waddr  = clr_idx_r[PHT_IDX_W-1:0];
      ctr_wdata  = '0;
      bias_we    = (32'(clr_idx_r) < 32'(BIAS_ENTRIES));
      bias_waddr = clr_idx_r[BIAS_IDX_W-1:0];
      bias_wdata = {1'b0, ~clr_idx_r[0]};
    end else if (state_r == BK_EXEC && ent_r.kind == KIND_RESOLVE) begin
      ctr_we  = 1'b1;
      bias_we = !rd_set;
    end
  end

  // History, clearing pass and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r       <= '0;
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == BK_EXEC) begin
        hist_r <= hist_nxt;
      end
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == CLR_W'(CLR_DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      out_valid_r <= (state_r == BK_EXEC);
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state_r == BK_EXEC) begin
      out_pred_r  <= res_pred;
      out_snap_r  <= hist_r;
      out_bias_r  <= res_bias;
      out_agree_r <= res_agree;
    end
  end

  abp_ram #(
    .WIDTH (CTR_BITS),
    .DEPTH (PHT_ENTRIES)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .raddr (pidx_rd),
    .rdata (ctr_rdata)
  );

  abp_ram #(
    .WIDTH (BIAS_W),
    .DEPTH (BIAS_ENTRIES)
  ) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr (bias_waddr),
    .wdata (bias_wdata),
    .raddr (head.bidx),
    .rdata (bias_rdata)
  );

  assign clearing             = clr_active_r;
  assign out_valid            = out_valid_r;
  assign out_prediction       = out_pred_r;
  assign out_history_snapshot = out_snap_r;
  assign out_bias_bit         = out_bias_r;
  assign out_agree_pred       = out_agree_r;

  // No request is taken up while the tables are being cleared.
  a_no_work_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (state_r == BK_IDLE && !pop))
    else $error("request started during clearing pass");

  // Each update cycle is followed by a result beat.
  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EXEC) |=> out_valid_r)
    else $error("update cycle without result beat");

  // History never holds bits beyond the counter index width.
  a_hist_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (hist_r & ~HIST_MASK) == '0)
    else $error("history has bits outside mask");

endmodule

FILE: hw/rtl/agree_branch_predictor.sv
// Channel   Ports                                          Handshake
// input     in_req_type, in_branch_addr, in_taken,         start high, busy low
//           in_squashed, in_saved_history
// result    out_prediction, out_history_snapshot,          out_valid, one cycle
//           out_bias_bit, out_agree_pred
// config    cfg_inst_shift                                 cfg_valid and cfg_ready
//
// A request enters a two-beat queue at the accepting edge; the back end reads
// both tables as it pops the queue and updates them in the next cycle; the
// result beat is registered from that update onto the ports.
// The back end completes one request's read-then-write of the counter and bias
// tables before it pops the next; the queue can take requests meanwhile.
// After reset busy stays high while the tables are cleared.
// busy also rises when the queue holds two beats; results cannot be held off.
module agree_branch_predictor import abp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [ADDR_W-1:0]  in_branch_addr,
  input  logic               in_taken,
  input  logic               in_squashed,
  input  logic [HIST_W-1:0]  in_saved_history,
  output logic               out_valid,
  output logic               out_prediction,
  output logic [HIST_W-1:0]  out_history_snapshot,
  output logic               out_bias_bit,
  output logic               out_agree_pred,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SHIFT_W-1:0] cfg_inst_shift
);

  logic [SHIFT_W-1:0] inst_shift_r;
  q_entry_t           front_entry;
  q_entry_t           q_head;
  logic               q_empty;
  logic               q_full;
  logic               q_pop;
  logic               clearing;
  logic               accept;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inst_shift_r <= INST_SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      inst_shift_r <= cfg_inst_shift;
    end
  end

  // Input handshake.
  assign busy   = q_full | clearing;
  assign accept = start & ~busy;

  abp_front u_front (
    .req_type      (in_req_type),
    .branch_addr   (in_branch_addr),
    .taken         (in_taken),
    .squashed      (in_squashed),
    .saved_history (in_saved_history),
    .inst_shift    (inst_shift_r),
    .entry         (front_entry)
  );

  abp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (front_entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  abp_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (q_head),
    .empty                (q_empty),
    .pop                  (q_pop),
    .clearing             (clearing),
    .out_valid            (out_valid),
    .out_prediction       (out_prediction),
    .out_history_snapshot (out_history_snapshot),
    .out_bias_bit         (out_bias_bit),
    .out_agree_pred       (out_agree_pred)
  );

endmodule

FILE: verif/agree_branch_predictor_tb.sv
module agree_branch_predictor_tb;
  import abp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Request codes that the block treats as no-ops.
  localparam logic [REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_MID = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI  = 3'd7;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 400;
  localparam int ADDR_POOL    = 20;
  localparam int MAX_PENDING  = 32;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    logic              taken;
    logic              squashed;
    logic [HIST_W-1:0] saved;
  } branch_req_t;

  typedef struct packed {
    logic              pred;
    logic [HIST_W-1:0] snap;
    logic              bias;
    logic              agree;
  } branch_res_t;

  typedef struct packed {
    branch_req_t rq;
    logic        typed;
    branch_res_t res;
  } dir_row_t;

  // A lookup whose outcome has not been resolved yet.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [HIST_W-1:0] snap;
    logic              pred;
  } open_lookup_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [REQ_W-1:0]   in_req_type = '0;
  logic [ADDR_W-1:0]  in_branch_addr = '0;
  logic               in_taken = 1'b0;
  logic               in_squashed = 1'b0;
  logic [HIST_W-1:0]  in_saved_history = '0;
  logic               out_valid;
  logic               out_prediction;
  logic [HIST_W-1:0]  out_history_snapshot;
  logic               out_bias_bit;
  logic               out_agree_pred;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [SHIFT_W-1:0] cfg_inst_shift = '0;

  // Shadow copy of the predictor state.
  logic [SHIFT_W-1:0]  shift_model;
  logic [HIST_W-1:0]   ghist_model;
  logic                bias_model    [BIAS_ENTRIES];
  logic                bias_written  [BIAS_ENTRIES];
  logic [CTR_BITS-1:0] agree_ctr_model [PHT_ENTRIES];

  branch_res_t  expected_beats [$];
  open_lookup_t open_lookups [$];
  dir_row_t     directed_rows [$];
  logic [ADDR_W-1:0] addr_pool [ADDR_POOL];
  branch_res_t  head_beat;
  int           idle_pct = 0;
  int           fail_cnt = 0;
  int           cycle_cnt = 0;

  agree_branch_predictor uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_branch_addr       (in_branch_addr),
    .in_taken             (in_taken),
    .in_squashed          (in_squashed),
    .in_saved_history     (in_saved_history),
    .out_valid            (out_valid),
    .out_prediction       (out_prediction),
    .out_history_snapshot (out_history_snapshot),
    .out_bias_bit         (out_bias_bit),
    .out_agree_pred       (out_agree_pred),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_inst_shift       (cfg_inst_shift)
  );

  always #4 clk = ~clk;

  // Computes the result beat of one request and advances the shadow state.
  function automatic branch_res_t predict_branch(input branch_req_t r);
    logic [ADDR_W-1:0]     sh;
    logic [BIAS_IDX_W-1:0] bi;
    logic [PHT_IDX_W-1:0]  pi;
    logic [CTR_BITS-1:0]   c;
    branch_res_t           res;
    res = '0;
    res.snap = ghist_model;
    sh = r.addr >> shift_model;
    bi = BIAS_IDX_W'(sh);
    case (r.req)
      REQ_LOOKUP: begin
        pi = PHT_IDX_W'(sh ^ ADDR_W'(ghist_model));
        res.bias = bias_model[bi];
        res.agree = (agree_ctr_model[pi] > CTR_THRESH);
        res.pred = res.agree ? res.bias : ~res.bias;
        ghist_model = {ghist_model[HIST_W-2:0], res.pred} & HIST_MASK;
      end
      REQ_UNCOND: begin
        res.pred = 1'b1;
        res.bias = 1'b1;
        res.agree = 1'b1;
        ghist_model = {ghist_model[HIST_W-2:0], 1'b1} & HIST_MASK;
      end
      REQ_RESOLVE: begin
        pi = PHT_IDX_W'(sh ^ ADDR_W'(r.saved));
        c = agree_ctr_model[pi];
        res.bias = bias_model[bi];
        res.agree = (r.taken == res.bias);
        if (res.agree && c != CTR_MAX) begin
          c = c + 1'b1;
        end else if (!res.agree && c != '0) begin
          c = c - 1'b1;
        end
        agree_ctr_model[pi] = c;
        if (r.squashed) begin
          ghist_model = {r.saved[HIST_W-2:0], r.taken} & HIST_MASK;
        end
        // The first outcome seen for a bias entry becomes its bias.
        if (!bias_written[bi]) begin
          bias_written[bi] = 1'b1;
          bias_model[bi] = r.taken;
        end
      end
      REQ_RESTORE: begin
        ghist_model = r.saved & HIST_MASK;
      end
      REQ_BTB_MISS: begin
        ghist_model = ghist_model & HIST_MASK & ~HIST_W'(1);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic add_row(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                         input logic taken, input logic squashed,
                         input logic [HIST_W-1:0] saved, input logic typed,
                         input logic pred, input logic [HIST_W-1:0] snap,
                         input logic bias, input logic agree);
    dir_row_t row;
    row.rq = '{req, addr, taken, squashed, saved};
    row.typed = typed;
    row.res = '{pred, snap, bias, agree};
    directed_rows.push_back(row);
  endtask

  // Drives one request beat, waits for it to be taken and records its result.
  task automatic send_req(input branch_req_t r, input logic typed,
                          input branch_res_t typed_res);
    branch_res_t  res;
    open_lookup_t ol;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= r.req;
    in_branch_addr <= r.addr;
    in_taken <= r.taken;
    in_squashed <= r.squashed;
    in_saved_history <= r.saved;
    do @(posedge clk); while (busy);
    res = predict_branch(r);
    expected_beats.push_back(typed ? typed_res : res);
    if (r.req == REQ_LOOKUP) begin
      ol = '{r.addr, res.snap, res.pred};
      open_lookups.push_back(ol);
      if (open_lookups.size() > MAX_PENDING) begin
        void'(open_lookups.pop_front());
      end
    end
  endtask

  // Builds a random request, mostly lookups and resolves of earlier lookups with their snapshots.
  task automatic make_random_req(output branch_req_t r);
    int           w;
    int           k;
    open_lookup_t ol;
    r.req = REQ_LOOKUP;
    r.addr = ($urandom_range(99) < 80) ? addr_pool[$urandom_range(ADDR_POOL - 1)] : $urandom;
    r.taken = $urandom_range(1);
    r.squashed = $urandom_range(1);
    r.saved = HIST_W'($urandom);
    w = $urandom_range(99);
    if (w < 38) begin
      r.req = REQ_LOOKUP;
    end else if (w < 48) begin
      r.req = REQ_UNCOND;
    end else if (w < 78) begin
      r.req = REQ_RESOLVE;
      if (open_lookups.size() != 0 && $urandom_range(99) < 85) begin
        k = $urandom_range(open_lookups.size() - 1);
        ol = open_lookups[k];
        open_lookups.delete(k);
        r.addr = ol.addr;
        r.saved = ol.snap;
        r.taken = ($urandom_range(99) < 75) ? ol.pred : ~ol.pred;
        r.squashed = (r.taken != ol.pred);
        if ($urandom_range(99) < 10) begin
          r.squashed = ~r.squashed;
        end
      end
    end else if (w < 85) begin
      r.req = REQ_RESTORE;
      if (open_lookups.size() != 0 && $urandom_range(99) < 70) begin
        r.saved = open_lookups[$urandom_range(open_lookups.size() - 1)].snap;
      end
    end else if (w < 92) begin
      r.req = REQ_BTB_MISS;
    end else begin
      r.req = REQ_SPARE_LO + REQ_W'($urandom_range(2));
    end
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the shift register once the block has gone quiet.
  task automatic write_shift(input logic [SHIFT_W-1:0] v);
    start <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_inst_shift <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shift_model = v;
  endtask

  // Compares every result beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no request outstanding");
        fail_cnt++;
      end else begin
        head_beat = expected_beats.pop_front();
        if (out_prediction !== head_beat.pred) begin
          $error("prediction: expected %0d, got %0d", head_beat.pred, out_prediction);
          fail_cnt++;
        end
        if (out_history_snapshot !== head_beat.snap) begin
          $error("history_snapshot: expected %0h, got %0h", head_beat.snap,
                 out_history_snapshot);
          fail_cnt++;
        end
        if (out_bias_bit !== head_beat.bias) begin
          $error("bias_bit: expected %0d, got %0d", head_beat.bias, out_bias_bit);
          fail_cnt++;
        end
        if (out_agree_pred !== head_beat.agree) begin
          $error("agree_pred: expected %0d, got %0d", head_beat.agree, out_agree_pred);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    branch_req_t r;
    int          n;
    int          p;
    logic [SHIFT_W-1:0] phase_shift [4];
    int          phase_idle [4];

    phase_shift = '{2'd0, 2'd3, 2'd1, 2'd2};
    phase_idle = '{27, 63, 0, 0};

    // Shadow state after reset.
    shift_model = INST_SHIFT_RST;
    ghist_model = '0;
    for (int i = 0; i < BIAS_ENTRIES; i++) begin
      bias_model[i] = ~i[0];
      bias_written[i] = 1'b0;
    end
    for (int i = 0; i < PHT_ENTRIES; i++) begin
      agree_ctr_model[i] = '0;
    end
    for (int i = 0; i < ADDR_POOL; i++) begin
      addr_pool[i] = $urandom;
    end

    // Directed rows: table extremes, every request kind, saturation and bias setting.
    add_row(REQ_LOOKUP,   32'h0000_0000, 0, 0, 12'h000, 1, 0, 12'h000, 1, 0);
    add_row(REQ_LOOKUP,   32'hFFFF_FFFF, 0, 0, 12'h000, 1, 1, 12'h000, 0, 0);
    add_row(REQ_UNCOND,   32'h0000_0000, 0, 0, 12'h000, 1, 1, 12'h001, 1, 1);
    add_row(REQ_BTB_MISS, 32'h0000_0000, 0, 0, 12'h000, 1, 0, 12'h003, 0, 0);
    add_row(REQ_RESTORE,  32'h0000_0000, 0, 0, 12'hFFF, 1, 0, 12'h002, 0, 0);
    add_row(REQ_SPARE_LO, 32'hFFFF_FFFF, 1, 1, 12'hFFF, 1, 0, 12'hFFF, 0, 0);
    add_row(REQ_SPARE_HI, 32'h1234_5678, 1, 0, 12'h000, 1, 0, 12'hFFF, 0, 0);
    add_row(REQ_SPARE_MID, 32'h0, 0, 1, 12'hABC, 1, 0, 12'hFFF, 0, 0);
    add_row(REQ_RESOLVE,  32'h0000_0000, 1, 0, 12'h000, 1, 0, 12'hFFF, 1, 1);
    add_row(REQ_RESOLVE,  32'h0000_0004, 0, 1, 12'hFFF, 1, 0, 12'hFFF, 0, 1);
    add_row(REQ_RESOLVE,  32'h0000_0008, 0, 0, 12'h000, 0, 0, 0, 0, 0);
    add_row(REQ_RESOLVE,  32'h0000_0008, 1, 0, 12'h000, 0, 0, 0, 0, 0);
    repeat (4) add_row(REQ_RESOLVE, 32'h0000_0010, 1, 0, 12'h000, 0, 0, 0, 0, 0);
    add_row(REQ_RESTORE,  32'h0000_0000, 0, 0, 12'h000, 0, 0, 0, 0, 0);
    add_row(REQ_LOOKUP,   32'h0000_0010, 0, 0, 12'h000, 0, 0, 0, 0, 0);
    add_row(REQ_LOOKUP,   32'h0000_0008, 0, 0, 12'h000, 0, 0, 0, 0, 0);
    add_row(REQ_RESOLVE,  32'hFFFF_FFFC, 1, 1, 12'hABC, 0, 0, 0, 0, 0);
    add_row(REQ_LOOKUP,   32'hDEAD_BEEF, 0, 0, 12'h000, 0, 0, 0, 0, 0);
    add_row(REQ_BTB_MISS, 32'h5A5A_A5A5, 1, 1, 12'h555, 0, 0, 0, 0, 0);
    add_row(REQ_RESOLVE,  32'h8000_0000, 0, 1, 12'h555, 0, 0, 0, 0, 0);

    // Hold reset first; busy covers the table clearing pass afterward.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_req(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);
    end

    // Random phases, each under its own shift setting and with a chosen sender idling rate.
    for (p = 0; p < 4; p++) begin
      write_shift(phase_shift[p]);
      idle_pct = phase_idle[p];
      open_lookups.delete();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        make_random_req(r);
        send_req(r, 1'b0, '0);
      end
    end

    start <= 1'b0;
    wait_drained();
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/abp_pkg.sv
hw/rtl/abp_ram.sv
hw/rtl/abp_front.sv
hw/rtl/abp_queue.sv
hw/rtl/abp_back.sv
hw/rtl/agree_branch_predictor.sv
verif/agree_branch_predictor_tb.sv
